@@ src/bmh_pkg.sv @@
// Shared types and constants for the binary min-heap engine.
// No dependencies; compiled first.
`default_nettype none

package bmh_pkg;

	localparam int unsigned HEAP_DEPTH_DEF = 256;
	localparam int unsigned KEY_W          = 32;
	localparam int unsigned OP_W           = 3;
	localparam int unsigned INDEX_W        = 8;
	localparam int unsigned STATUS_W       = 2;
	localparam int unsigned COUNT_W        = 9;

	typedef logic signed [KEY_W-1:0] key_t;

	localparam key_t KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};
	localparam key_t KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};

	typedef enum logic [OP_W-1:0] {
		OP_LOAD    = 3'd0,
		OP_BUILD   = 3'd1,
		OP_UPDATE  = 3'd2,
		OP_DELETE  = 3'd3,
		OP_EXTRACT = 3'd4
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

endpackage

`default_nettype wire

@@ src/bmh_req_if.sv @@
// Request channel of the heap engine: valid/ready plus operation payload.
// Depends on bmh_pkg for field widths.
`default_nettype none

interface bmh_req_if;
	logic                              valid;
	logic                              ready;
	logic [bmh_pkg::OP_W-1:0]          op;
	logic [bmh_pkg::INDEX_W-1:0]       index;
	logic signed [bmh_pkg::KEY_W-1:0]  key_value;

	modport source (output valid, output op, output index, output key_value, input ready);
	modport sink   (input valid, input op, input index, input key_value, output ready);
endinterface

`default_nettype wire

@@ src/bmh_rsp_if.sv @@
// Response channel of the heap engine: valid/ready plus result payload.
// Depends on bmh_pkg for field widths.
`default_nettype none

interface bmh_rsp_if;
	logic                              valid;
	logic                              ready;
	logic signed [bmh_pkg::KEY_W-1:0]  min_key;
	logic [bmh_pkg::STATUS_W-1:0]      status;
	logic [bmh_pkg::COUNT_W-1:0]       entry_count;

	modport source (output valid, output min_key, output status, output entry_count, input ready);
	modport sink   (input valid, input min_key, input status, input entry_count, output ready);
endinterface

`default_nettype wire

@@ src/bmh_key_ram.sv @@
// Key store: one write port, two read ports, registered read data.
// Depends on bmh_pkg for the key type.
`default_nettype none

module bmh_key_ram #(
	parameter int unsigned DEPTH = bmh_pkg::HEAP_DEPTH_DEF,
	localparam int unsigned AW   = $clog2(DEPTH)
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire bmh_pkg::key_t wdata,
	input  wire logic [AW-1:0] ra_addr,
	input  wire logic [AW-1:0] rb_addr,
	output bmh_pkg::key_t      ra_data,
	output bmh_pkg::key_t      rb_data
);
	import bmh_pkg::*;

	key_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		ra_data <= mem[ra_addr];
		rb_data <= mem[rb_addr];
	end

endmodule

`default_nettype wire

@@ src/binary_min_heap_engine.sv @@
// Binary min-heap engine: array-held heap of signed keys in a 2R/1W sync RAM.
// Load, rejects and unused ops go straight to the result; update climbs toward the root;
// extract moves the last entry into the root and sifts it down; delete first climbs the entry
// to the root, then removes it as extract does; build sifts down each interior node in turn.
// One item at a time: next item accepted the edge after its result is registered.
// Reset: count cleared, no result pending; key RAM is not cleared.
`default_nettype none

module binary_min_heap_engine #(
	parameter int unsigned HEAP_DEPTH = bmh_pkg::HEAP_DEPTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	bmh_req_if.sink  req,
	bmh_rsp_if.source rsp
);
	import bmh_pkg::*;

	// AW addresses the store, CW holds 0..HEAP_DEPTH, XW holds child indexes.
	localparam int unsigned AW  = $clog2(HEAP_DEPTH);
	localparam int unsigned CW  = $clog2(HEAP_DEPTH + 1);
	localparam int unsigned XW  = AW + 1;
	localparam int unsigned IXW = (CW > INDEX_W) ? CW : INDEX_W;

	// Sequencer states. UP_* walk a hole toward the root, DN_* walk it toward
	// the leaves; RM_* pull the last entry into the root; BLD_* pick the next
	// interior node during heapify.
	typedef enum logic [3:0] {
		S_IDLE,
		S_DEL_RD,
		S_UP_RD,
		S_UP_CMP,
		S_RM_RD,
		S_RM_LAST,
		S_DN_RD,
		S_DN_CMP,
		S_BLD_RD,
		S_BLD_LD,
		S_FINISH
	} state_t;

	state_t          state_q;
	op_t             op_q;
	logic [CW-1:0]   count_q;
	logic [AW-1:0]   p_q;       // current hole position
	logic [AW-1:0]   node_q;    // heapify node
	key_t            m_q;       // key riding the hole
	key_t            result_q;
	status_t         status_q;

	logic                rsp_valid_q;
	key_t                rsp_min_key_q;
	status_t             rsp_status_q;
	logic [COUNT_W-1:0]  rsp_count_q;

	// RAM ports
	logic          we;
	logic [AW-1:0] waddr;
	key_t          wdata;
	logic [AW-1:0] ra_addr;
	logic [AW-1:0] rb_addr;
	key_t          rd_a;
	key_t          rd_b;

	bmh_key_ram #(
		.DEPTH(HEAP_DEPTH)
	) u_ram (
		.clk    (clk),
		.we     (we),
		.waddr  (waddr),
		.wdata  (wdata),
		.ra_addr(ra_addr),
		.rb_addr(rb_addr),
		.ra_data(rd_a),
		.rb_data(rd_b)
	);

	// Handshake: take a new item whenever the sequencer is idle; the response
	// register lets a finished result wait without blocking the next request.
	logic accept;
	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;

	assign rsp.valid       = rsp_valid_q;
	assign rsp.min_key     = rsp_min_key_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.entry_count = rsp_count_q;

	// Derived addresses and conditions
	logic          full;
	logic          idx_ok;
	logic [AW-1:0] last_addr;
	logic [AW-1:0] parent;
	logic [XW-1:0] l_x;
	logic [XW-1:0] r_x;
	logic          l_ok;
	logic          r_ok;
	logic          up_swap;
	logic          sel_l;
	logic          sel_r;
	key_t          cur_min;
	logic          bld_more;

	assign full      = (count_q == CW'(HEAP_DEPTH));
	assign idx_ok    = IXW'(req.index) < IXW'(count_q);
	assign last_addr = AW'(count_q - CW'(1));
	assign parent    = (p_q - AW'(1)) >> 1;
	assign l_x       = {p_q, 1'b1};
	assign r_x       = l_x + XW'(1);
	assign l_ok      = l_x < XW'(count_q);
	assign r_ok      = r_x < XW'(count_q);
	assign up_swap   = m_q < rd_a;

	// Smallest of hole key, left child, right child; ties keep the earlier one.
	assign sel_l    = l_ok && (rd_a < m_q);
	assign cur_min  = sel_l ? rd_a : m_q;
	assign sel_r    = r_ok && (rd_b < cur_min);
	assign bld_more = (op_q == OP_BUILD) && (node_q != '0);

	// RAM access per state
	always_comb begin
		we      = 1'b0;
		waddr   = p_q;
		wdata   = m_q;
		ra_addr = '0;
		rb_addr = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (req.op)
						OP_LOAD: begin
							if (!full) begin
								we    = 1'b1;
								waddr = count_q[AW-1:0];
								wdata = req.key_value;
							end
						end
						OP_DELETE: ra_addr = AW'(req.index);
						OP_EXTRACT: begin
							ra_addr = '0;
							rb_addr = last_addr;
						end
						default: ;
					endcase
				end
			end
			S_UP_RD: begin
				if (p_q == '0) begin
					we = 1'b1;
				end else begin
					ra_addr = parent;
				end
			end
			S_UP_CMP: begin
				we    = 1'b1;
				wdata = up_swap ? rd_a : m_q;
			end
			S_RM_RD: rb_addr = last_addr;
			S_DN_RD: begin
				if (!l_ok) begin
					we = 1'b1;
				end else begin
					ra_addr = l_x[AW-1:0];
					rb_addr = r_x[AW-1:0];
				end
			end
			S_DN_CMP: begin
				we    = 1'b1;
				wdata = sel_r ? rd_b : cur_min;
			end
			S_BLD_RD: ra_addr = node_q;
			default: ;
		endcase
	end

	// Sequencer, count and response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			op_q          <= OP_LOAD;
			count_q       <= '0;
			p_q           <= '0;
			node_q        <= '0;
			m_q           <= '0;
			result_q      <= '0;
			status_q      <= ST_OK;
			rsp_valid_q   <= 1'b0;
			rsp_min_key_q <= '0;
			rsp_status_q  <= ST_OK;
			rsp_count_q   <= '0;
		end else begin
			// taken result drops unless a new one replaces it this edge
			if (rsp_valid_q && rsp.ready && (state_q != S_FINISH)) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q <= op_t'(req.op);
						case (req.op)
							OP_LOAD: begin
								result_q <= '0;
								state_q  <= S_FINISH;
								if (full) begin
									status_q <= ST_FULL;
								end else begin
									status_q <= ST_OK;
									count_q  <= count_q + CW'(1);
								end
							end
							OP_BUILD: begin
								result_q <= '0;
								status_q <= ST_OK;
								if (count_q >= CW'(2)) begin
									node_q  <= AW'((count_q >> 1) - CW'(1));
									state_q <= S_BLD_RD;
								end else begin
									state_q <= S_FINISH;
								end
							end
							OP_UPDATE: begin
								result_q <= '0;
								if (!idx_ok) begin
									status_q <= ST_RANGE;
									state_q  <= S_FINISH;
								end else begin
									status_q <= ST_OK;
									m_q      <= req.key_value;
									p_q      <= AW'(req.index);
									state_q  <= S_UP_RD;
								end
							end
							OP_DELETE: begin
								result_q <= '0;
								if (!idx_ok) begin
									status_q <= ST_RANGE;
									state_q  <= S_FINISH;
								end else begin
									status_q <= ST_OK;
									m_q      <= KEY_MIN;
									p_q      <= AW'(req.index);
									state_q  <= S_DEL_RD;
								end
							end
							OP_EXTRACT: begin
								if (count_q == '0) begin
									result_q <= KEY_MAX;
									status_q <= ST_EMPTY;
									state_q  <= S_FINISH;
								end else begin
									// root and last entry already being read
									result_q <= '0;
									status_q <= ST_OK;
									state_q  <= S_RM_LAST;
								end
							end
							default: begin
								result_q <= '0;
								status_q <= ST_OK;
								state_q  <= S_FINISH;
							end
						endcase
					end
				end
				S_DEL_RD: begin
					result_q <= rd_a;
					state_q  <= S_UP_RD;
				end
				S_UP_RD: begin
					if (p_q == '0) begin
						state_q <= (op_q == OP_DELETE) ? S_RM_RD : S_FINISH;
					end else begin
						state_q <= S_UP_CMP;
					end
				end
				S_UP_CMP: begin
					if (up_swap) begin
						p_q     <= parent;
						state_q <= S_UP_RD;
					end else begin
						state_q <= (op_q == OP_DELETE) ? S_RM_RD : S_FINISH;
					end
				end
				S_RM_RD: state_q <= S_RM_LAST;
				S_RM_LAST: begin
					if (op_q == OP_EXTRACT) begin
						result_q <= rd_a;
					end
					m_q     <= rd_b;
					p_q     <= '0;
					count_q <= count_q - CW'(1);
					state_q <= (count_q == CW'(1)) ? S_FINISH : S_DN_RD;
				end
				S_DN_RD: begin
					if (!l_ok) begin
						if (bld_more) begin
							node_q  <= node_q - AW'(1);
							state_q <= S_BLD_RD;
						end else begin
							state_q <= S_FINISH;
						end
					end else begin
						state_q <= S_DN_CMP;
					end
				end
				S_DN_CMP: begin
					if (sel_r) begin
						p_q     <= r_x[AW-1:0];
						state_q <= S_DN_RD;
					end else if (sel_l) begin
						p_q     <= l_x[AW-1:0];
						state_q <= S_DN_RD;
					end else if (bld_more) begin
						node_q  <= node_q - AW'(1);
						state_q <= S_BLD_RD;
					end else begin
						state_q <= S_FINISH;
					end
				end
				S_BLD_RD: state_q <= S_BLD_LD;
				S_BLD_LD: begin
					m_q     <= rd_a;
					p_q     <= node_q;
					state_q <= S_DN_RD;
				end
				S_FINISH: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q   <= 1'b1;
						rsp_min_key_q <= result_q;
						rsp_status_q  <= status_q;
						rsp_count_q   <= COUNT_W'(count_q);
						state_q       <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
// Self-checking bench for binary_min_heap_engine: drives heap operations over the
// request channel and checks each response against an in-bench heap predictor.
// Depends on bmh_pkg, bmh_req_if, bmh_rsp_if and the engine RTL.
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import bmh_pkg::*;

	localparam int unsigned DEPTH = HEAP_DEPTH_DEF;

	// op codes the engine does not decode; it must answer them with a plain ok
	localparam logic [OP_W-1:0] OP_SPARE_5 = 3'd5;
	localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

	typedef struct packed {
		key_t                 min_key;
		status_t              status;
		logic [COUNT_W-1:0]   entry_count;
	} heap_result_t;

	logic clk;
	logic arst_n;

	bmh_req_if req_ch ();
	bmh_rsp_if rsp_ch ();

	binary_min_heap_engine #(
		.HEAP_DEPTH(DEPTH)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	// ------------------------------------------------------------------
	// Predictor state: shadow copy of the heap array and its fill count.
	// Updated when an item is accepted, so the stimulus code may also read
	// it to aim updates and deletes at live positions.
	// ------------------------------------------------------------------
	key_t         heap_keys [DEPTH];
	int unsigned  heap_size;

	heap_result_t pending_results [$];   // expected responses, oldest first
	int unsigned  mismatch_count;
	bit           no_gaps;               // when set, neither side idles
	int unsigned  rsp_hold_cycles;       // one-shot long stall for the receiver

	// ------------------------------------------------------------------
	// Heap predictor
	// ------------------------------------------------------------------
	function automatic void swap_keys(int unsigned a, int unsigned b);
		key_t t;
		t = heap_keys[a];
		heap_keys[a] = heap_keys[b];
		heap_keys[b] = t;
	endfunction

	// walk down while a child is strictly smaller; ties stay in place
	function automatic void sift_down_from(int unsigned pos, int unsigned cnt);
		int unsigned best;
		int unsigned lc;
		int unsigned rc;
		bit settled;
		settled = 1'b0;
		while (!settled) begin
			best = pos;
			lc = 2 * pos + 1;
			rc = 2 * pos + 2;
			if (lc < cnt && heap_keys[lc] < heap_keys[best])
				best = lc;
			if (rc < cnt && heap_keys[rc] < heap_keys[best])
				best = rc;
			if (best == pos)
				settled = 1'b1;
			else begin
				swap_keys(pos, best);
				pos = best;
			end
		end
	endfunction

	function automatic void sift_up_from(int unsigned pos);
		int unsigned up;
		bit settled;
		settled = 1'b0;
		while (pos != 0 && !settled) begin
			up = (pos - 1) / 2;
			if (heap_keys[pos] < heap_keys[up]) begin
				swap_keys(pos, up);
				pos = up;
			end else
				settled = 1'b1;
		end
	endfunction

	// last entry moves to the root, then sifts down over the shrunk heap
	function automatic key_t pop_root();
		key_t top;
		top = heap_keys[0];
		heap_size--;
		heap_keys[0] = heap_keys[heap_size];
		sift_down_from(0, heap_size);
		return top;
	endfunction

	// applies one accepted operation to the shadow heap, returns the response
	function automatic heap_result_t heap_apply(logic [OP_W-1:0] op,
			logic [INDEX_W-1:0] idx, key_t key);
		heap_result_t res;
		int unsigned i;
		res.min_key = '0;
		res.status  = ST_OK;
		case (op)
			OP_LOAD: begin
				if (heap_size >= DEPTH)
					res.status = ST_FULL;   // key dropped
				else begin
					heap_keys[heap_size] = key;
					heap_size++;
				end
			end
			OP_BUILD: begin
				// no-op for fewer than two entries
				for (i = heap_size / 2; i > 0; i--)
					sift_down_from(i - 1, heap_size);
			end
			OP_UPDATE: begin
				if (idx >= heap_size)
					res.status = ST_RANGE;
				else begin
					// upward only: a larger key can leave order broken below
					heap_keys[idx] = key;
					sift_up_from(idx);
				end
			end
			OP_DELETE: begin
				if (idx >= heap_size)
					res.status = ST_RANGE;
				else begin
					res.min_key = heap_keys[idx];
					heap_keys[idx] = KEY_MIN;
					sift_up_from(idx);
					void'(pop_root());
				end
			end
			OP_EXTRACT: begin
				if (heap_size == 0) begin
					res.min_key = KEY_MAX;
					res.status  = ST_EMPTY;
				end else
					res.min_key = pop_root();
			end
			default: begin
			end
		endcase
		res.entry_count = COUNT_W'(heap_size);
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Random helpers
	// ------------------------------------------------------------------
	// mostly back-to-back or short gaps, now and then a long one
	function automatic int unsigned pick_gap();
		int unsigned roll;
		if (no_gaps)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 88)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// full-range keys, a narrow band around zero for ties, and both rails
	function automatic key_t rand_key();
		int unsigned pick;
		pick = $urandom_range(0, 9);
		if (pick < 5)
			return key_t'($urandom);
		if (pick < 8)
			return key_t'($urandom_range(0, 100)) - 50;
		if (pick == 8)
			return KEY_MAX - key_t'($urandom_range(0, 3));
		return KEY_MIN + key_t'($urandom_range(0, 3));
	endfunction

	function automatic logic [INDEX_W-1:0] rand_index();
		return INDEX_W'($urandom_range(0, DEPTH - 1));
	endfunction

	// ------------------------------------------------------------------
	// Request driver. Payload goes out at a clock edge, then we wait for
	// the edge where ready is seen high. valid is only dropped when a gap
	// follows, so back-to-back items never lower and raise valid in the
	// same time step.
	// ------------------------------------------------------------------
	task automatic send_item(input logic [OP_W-1:0] op, input logic [INDEX_W-1:0] idx,
			input key_t key);
		int unsigned gap;
		req_ch.valid     <= 1'b1;
		req_ch.op        <= op;
		req_ch.index     <= idx;
		req_ch.key_value <= key;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		pending_results.push_back(heap_apply(op, idx, key));
		gap = pick_gap();
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// stop offering, let every expected response land, then a short margin
	task automatic wait_drain();
		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	// edge cases on an empty and a tiny heap, every defined op code plus two spare ones, both key rails
	task automatic test_directed();
		send_item(OP_EXTRACT, 8'd0, '0);          // empty extract
		send_item(OP_BUILD, 8'd0, '0);            // build with nothing held
		send_item(OP_UPDATE, 8'd0, 32'sd5);       // index equal to count (empty heap)
		send_item(OP_DELETE, 8'hFF, -32'sd1);     // index beyond count
		send_item(OP_SPARE_5, 8'hA5, 32'sh5A5A5A5A);
		send_item(OP_SPARE_7, 8'hFF, -32'sd1);
		send_item(OP_LOAD, 8'd0, KEY_MAX);
		send_item(OP_BUILD, 8'd0, '0);            // single entry: nothing to do
		send_item(OP_LOAD, 8'h55, KEY_MIN);
		send_item(OP_LOAD, 8'hAA, 32'sd0);
		send_item(OP_LOAD, 8'd0, -32'sd1);
		send_item(OP_LOAD, 8'd0, 32'sd1);
		send_item(OP_UPDATE, 8'd4, KEY_MIN);      // ties with its parent
		send_item(OP_UPDATE, 8'd5, 32'sd7);       // index equal to count
		send_item(OP_BUILD, 8'd0, '0);
		send_item(OP_UPDATE, 8'd0, KEY_MAX);      // increase at root, no sift down
		send_item(OP_DELETE, 8'd2, '0);
		send_item(OP_DELETE, 8'd0, '0);
		while (heap_size != 0)
			send_item(OP_EXTRACT, 8'd0, '0);
		send_item(OP_EXTRACT, 8'd0, '0);
		wait_drain();
	endtask

	// fill to capacity with no idling, hit full, work the last slot, drain
	task automatic test_fill_drain();
		no_gaps = 1'b1;
		while (heap_size < DEPTH)
			send_item(OP_LOAD, rand_index(), rand_key());
		no_gaps = 1'b0;
		send_item(OP_LOAD, 8'd0, 32'sd3);         // full: key dropped
		send_item(OP_UPDATE, 8'hFF, rand_key());
		send_item(OP_DELETE, 8'hFF, '0);
		send_item(OP_LOAD, 8'd0, rand_key());
		send_item(OP_UPDATE, 8'hFF, KEY_MIN);     // deepest leaf climbs to root
		send_item(OP_BUILD, 8'd0, '0);
		while (heap_size != 0)
			send_item(OP_EXTRACT, 8'd0, '0);
		send_item(OP_EXTRACT, 8'd0, '0);
		wait_drain();
	endtask

	// receiver holds off for a long stretch while items keep coming
	task automatic test_backpressure();
		no_gaps = 1'b1;
		rsp_hold_cycles = 400;
		repeat (8) send_item(OP_LOAD, rand_index(), rand_key());
		repeat (6) send_item(OP_EXTRACT, 8'd0, '0);
		repeat (6) send_item(OP_LOAD, rand_index(), rand_key());
		no_gaps = 1'b0;
		wait_drain();
		while (heap_size != 0)
			send_item(OP_EXTRACT, 8'd0, '0);
		wait_drain();
	endtask

	// mostly well-formed traffic aimed at live positions, some noise
	task automatic test_random_mix(input int unsigned n_items);
		int unsigned done_cnt;
		int unsigned pick;
		int unsigned burst;
		int unsigned pos;
		longint lowered;
		done_cnt = 0;
		while (done_cnt < n_items) begin
			pick = $urandom_range(0, 99);
			if (heap_size == 0 && pick < 95)
				pick = 0;                     // empty heap: mostly refill
			if (pick < 35) begin
				burst = (heap_size < 64) ? $urandom_range(1, 8) : $urandom_range(1, 2);
				repeat (burst) begin
					send_item(OP_LOAD, rand_index(), rand_key());
					done_cnt++;
				end
			end else if (pick < 42) begin
				send_item(OP_BUILD, rand_index(), rand_key());
				done_cnt++;
			end else if (pick < 60) begin
				pos = $urandom_range(0, heap_size - 1);
				if ($urandom_range(0, 3) != 0) begin
					// decrease-key, clamped at the bottom rail
					lowered = longint'(heap_keys[pos]) - longint'($urandom_range(0, 1000));
					if (lowered < longint'(KEY_MIN))
						lowered = longint'(KEY_MIN);
					send_item(OP_UPDATE, INDEX_W'(pos), key_t'(lowered));
				end else
					send_item(OP_UPDATE, INDEX_W'(pos), rand_key());
				done_cnt++;
			end else if (pick < 74) begin
				pos = $urandom_range(0, heap_size - 1);
				send_item(OP_DELETE, INDEX_W'(pos), rand_key());
				done_cnt++;
			end else if (pick < 95) begin
				send_item(OP_EXTRACT, rand_index(), rand_key());
				done_cnt++;
			end else begin
				case ($urandom_range(0, 2))
					0: begin
						if (heap_size < DEPTH) begin
							pos = $urandom_range(heap_size, DEPTH - 1);
							send_item($urandom_range(0, 1) ? OP_UPDATE : OP_DELETE,
								INDEX_W'(pos), rand_key());
							done_cnt++;
						end
					end
					1: begin
						// ignored by the engine, not counted
						send_item($urandom_range(0, 1) ? OP_SPARE_5 : OP_SPARE_7,
							rand_index(), rand_key());
					end
					default: begin
						send_item(OP_EXTRACT, rand_index(), rand_key());
						done_cnt++;
					end
				endcase
			end
		end
		wait_drain();
	endtask

	// ------------------------------------------------------------------
	// Clock and reset
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
	end

	// ------------------------------------------------------------------
	// Response ready: random stalls, runs of ready, and the one long hold
	// that a test can request through rsp_hold_cycles.
	// ------------------------------------------------------------------
	initial begin : rsp_ready_gen
		int unsigned stall;
		int unsigned run;
		rsp_ch.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (rsp_hold_cycles != 0) begin
				stall = rsp_hold_cycles;
				rsp_hold_cycles = 0;
			end else
				stall = pick_gap();
			if (stall != 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			run = no_gaps ? 1 : $urandom_range(1, 12);
			repeat (run) @(posedge clk);
		end
	end

	// ------------------------------------------------------------------
	// Response checker: every accepted response is matched against the
	// oldest expectation, field by field.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : rsp_check
		heap_result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected item: min_key %0d status %0d entry_count %0d",
					rsp_ch.min_key, rsp_ch.status, rsp_ch.entry_count);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				if (rsp_ch.min_key !== want.min_key) begin
					$error("min_key: expected %0d, got %0d", want.min_key, rsp_ch.min_key);
					mismatch_count++;
				end
				if (rsp_ch.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, rsp_ch.status);
					mismatch_count++;
				end
				if (rsp_ch.entry_count !== want.entry_count) begin
					$error("entry_count: expected %0d, got %0d", want.entry_count,
						rsp_ch.entry_count);
					mismatch_count++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	initial begin
		heap_size       = 0;
		mismatch_count  = 0;
		no_gaps         = 1'b0;
		rsp_hold_cycles = 0;
		req_ch.valid     <= 1'b0;
		req_ch.op        <= OP_LOAD;
		req_ch.index     <= '0;
		req_ch.key_value <= '0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		@(posedge clk);

		test_directed();
		test_fill_drain();
		test_backpressure();
		test_random_mix(400);

		if (mismatch_count == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

	// hard stop: far beyond the slowest legal run (full-heap builds included)
	initial begin
		#10_000_000;
		$display("tb_top: done, errors");
		$finish;
	end

endmodule

`default_nettype wire

@@ files.f @@
src/bmh_pkg.sv
src/bmh_req_if.sv
src/bmh_rsp_if.sv
src/bmh_key_ram.sv
src/binary_min_heap_engine.sv
test/tb_top.sv
